// ----- src/assert_macros.svh -----
// Assertion macros for the checker file, vda_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define VDA_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define VDA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- src/vda_pkg.sv -----
// Shared constants, types and functions of the vector distance accumulator.
package vda_pkg;

	localparam int LANES       = 4;
	localparam int ELEM_W      = 16;
	localparam int ACC_W       = 48;
	localparam int PROD_W      = 34;
	localparam int METRIC_W    = 2;
	localparam int VLEN_W      = 11;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 11;
	localparam int MAX_DIM_DEF = 1024;
	localparam int COS_Q_W     = 31;

	localparam logic [METRIC_W-1:0] METRIC_L2  = 2'd0;
	localparam logic [METRIC_W-1:0] METRIC_DOT = 2'd1;
	localparam logic [METRIC_W-1:0] METRIC_COS = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_METRIC = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_VLEN   = 1'b1;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	typedef enum logic [1:0] {ST_ACC, ST_FIN, ST_COS} state_t;

	typedef enum logic [2:0] {C_IDLE, C_SQRT, C_MUL, C_DIV0, C_DIV, C_DONE} cos_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} cos_stat_t;

	typedef struct packed {
		logic                     en;
		logic signed [PROD_W-1:0] main_p;
		logic signed [PROD_W-1:0] na_p;
		logic signed [PROD_W-1:0] nb_p;
	} lane_out_t;

	function automatic logic signed [ACC_W-1:0] sat_add(
		input logic signed [ACC_W-1:0]  acc,
		input logic signed [PROD_W-1:0] p
	);
		logic signed [ACC_W:0] s;
		s = {acc[ACC_W-1], acc} + {{(ACC_W+1-PROD_W){p[PROD_W-1]}}, p};
		if (s[ACC_W] != s[ACC_W-1]) begin
			return s[ACC_W] ? ACC_MIN : ACC_MAX;
		end
		return s[ACC_W-1:0];
	endfunction

endpackage

// ----- src/vda_lane.sv -----
// One lane: registered element products for the accumulators.
module vda_lane (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              take,
	input  logic                              in_range,
	input  logic                              l2,
	input  logic signed [vda_pkg::ELEM_W-1:0] a,
	input  logic signed [vda_pkg::ELEM_W-1:0] b,
	output vda_pkg::lane_out_t                q
);

	logic signed [vda_pkg::ELEM_W:0]   diff;
	logic signed [vda_pkg::PROD_W-1:0] main_s1, na_s1, nb_s1;
	logic                              en_s1;

	assign diff = {a[vda_pkg::ELEM_W-1], a} - {b[vda_pkg::ELEM_W-1], b};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1 <= 1'b0;
		end else begin
			en_s1 <= take & in_range;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			main_s1 <= l2 ? vda_pkg::PROD_W'(diff * diff) : vda_pkg::PROD_W'(a * b);
			na_s1   <= vda_pkg::PROD_W'(a * a);
			nb_s1   <= vda_pkg::PROD_W'(b * b);
		end
	end

	assign q = '{en: en_s1, main_p: main_s1, na_p: na_s1, nb_p: nb_s1};

endmodule

// ----- src/vda_merge.sv -----
// Merge stage: saturating accumulation of all lanes, in lane order.
module vda_merge (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             clear,
	input  vda_pkg::lane_out_t               lanes [vda_pkg::LANES],
	output logic signed [vda_pkg::ACC_W-1:0] main_sum,
	output logic signed [vda_pkg::ACC_W-1:0] norm_a,
	output logic signed [vda_pkg::ACC_W-1:0] norm_b
);

	logic signed [vda_pkg::ACC_W-1:0] main_q, na_q, nb_q;
	logic signed [vda_pkg::ACC_W-1:0] main_d, na_d, nb_d;

	// lanes add one after another so saturation matches element order
	always_comb begin
		main_d = main_q;
		na_d   = na_q;
		nb_d   = nb_q;
		for (int i = 0; i < vda_pkg::LANES; i++) begin
			if (lanes[i].en) begin
				main_d = vda_pkg::sat_add(main_d, lanes[i].main_p);
				na_d   = vda_pkg::sat_add(na_d, lanes[i].na_p);
				nb_d   = vda_pkg::sat_add(nb_d, lanes[i].nb_p);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_q <= '0;
			na_q   <= '0;
			nb_q   <= '0;
		end else if (clear) begin
			main_q <= '0;
			na_q   <= '0;
			nb_q   <= '0;
		end else begin
			main_q <= main_d;
			na_q   <= na_d;
			nb_q   <= nb_d;
		end
	end

	assign main_sum = main_q;
	assign norm_a   = na_q;
	assign norm_b   = nb_q;

endmodule

// ----- src/vda_cosine.sv -----
// Cosine magnitude: two bit-pair square roots, one multiply, restoring divide.
module vda_cosine (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [vda_pkg::ACC_W-1:0]  na,
	input  logic signed [vda_pkg::ACC_W-1:0]  nb,
	input  logic        [vda_pkg::ACC_W-1:0]  mag,
	output vda_pkg::cos_stat_t                stat,
	output logic        [vda_pkg::COS_Q_W-1:0] q
);

	localparam int DIV_STEPS = 46;
	localparam int CNT_W     = $clog2(DIV_STEPS);
	localparam logic [vda_pkg::ACC_W-1:0] Q_CAP = vda_pkg::ACC_W'(64'd1 << 30);

	vda_pkg::cos_state_t st_q, st_d;

	logic [63:0]              na_n_q, nb_n_q, ra_q, rb_q, bit_q, d_q;
	logic [64:0]              rem_q;
	logic [vda_pkg::ACC_W-1:0] mag_q, q_q;
	logic [CNT_W-1:0]         cnt_q;

	logic [63:0] sum_a, sum_b;
	logic        ge_a, ge_b, mag_ge_d, cap_now, div_ge;
	logic [64:0] d2, rem2, mag_x;

	assign sum_a    = ra_q + bit_q;
	assign sum_b    = rb_q + bit_q;
	assign ge_a     = na_n_q >= sum_a;
	assign ge_b     = nb_n_q >= sum_b;
	assign d2       = {d_q, 1'b0};
	assign mag_x    = {17'd0, mag_q};
	assign mag_ge_d = mag_x >= {1'b0, d_q};
	assign cap_now  = (d_q == 64'd0) || (mag_x >= d2);
	assign rem2     = {rem_q[63:0], 1'b0};
	assign div_ge   = rem2 >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= vda_pkg::C_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			vda_pkg::C_IDLE, vda_pkg::C_DONE: if (start) st_d = vda_pkg::C_SQRT;
			vda_pkg::C_SQRT: if (bit_q == 64'd1) st_d = vda_pkg::C_MUL;
			vda_pkg::C_MUL:  st_d = vda_pkg::C_DIV0;
			vda_pkg::C_DIV0: st_d = cap_now ? vda_pkg::C_DONE : vda_pkg::C_DIV;
			vda_pkg::C_DIV:  if (cnt_q == CNT_W'(DIV_STEPS - 1)) st_d = vda_pkg::C_DONE;
			default:         st_d = vda_pkg::C_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			vda_pkg::C_IDLE, vda_pkg::C_DONE: begin
				if (start) begin
					na_n_q <= {na[47:0], 16'd0};
					nb_n_q <= {nb[47:0], 16'd0};
					ra_q   <= '0;
					rb_q   <= '0;
					bit_q  <= 64'h4000_0000_0000_0000;
					mag_q  <= mag;
				end
			end
			vda_pkg::C_SQRT: begin
				if (ge_a) begin
					na_n_q <= na_n_q - sum_a;
					ra_q   <= (ra_q >> 1) + bit_q;
				end else begin
					ra_q   <= ra_q >> 1;
				end
				if (ge_b) begin
					nb_n_q <= nb_n_q - sum_b;
					rb_q   <= (rb_q >> 1) + bit_q;
				end else begin
					rb_q   <= rb_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			vda_pkg::C_MUL: d_q <= ra_q[31:0] * rb_q[31:0];
			vda_pkg::C_DIV0: begin
				cnt_q <= '0;
				if (cap_now) begin
					q_q <= Q_CAP;
				end else if (mag_ge_d) begin
					q_q   <= vda_pkg::ACC_W'(1);
					rem_q <= mag_x - {1'b0, d_q};
				end else begin
					q_q   <= '0;
					rem_q <= mag_x;
				end
			end
			vda_pkg::C_DIV: begin
				cnt_q <= cnt_q + 1'b1;
				rem_q <= div_ge ? rem2 - {1'b0, d_q} : rem2;
				q_q   <= {q_q[vda_pkg::ACC_W-2:0], div_ge};
			end
			default: ;
		endcase
	end

	assign stat.busy = (st_q != vda_pkg::C_IDLE) && (st_q != vda_pkg::C_DONE);
	assign stat.done = (st_q == vda_pkg::C_DONE);
	assign q = (q_q > Q_CAP) ? vda_pkg::COS_Q_W'(Q_CAP) : q_q[vda_pkg::COS_Q_W-1:0];

endmodule

// ----- src/vector_distance_accumulator.sv -----
// Top level of the vector distance accumulator.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid/in_ready, a_lane0..3, b_lane0..3 | into block
//  out     | out_valid/out_ready, distance, zero_norm  | out of block
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data  | into block
//
// Items stream one transfer per cycle while a vector is in progress. After the
// last item of a vector the input holds through the product and merge stages
// plus, for cosine, 32 square root steps, a multiply, a divide setup, up to 46
// divide steps and the done state; a new vector is not taken until its result
// is loaded.
// The finished result sits in an output register; a stalled output only holds
// the next vector's finish, not its streaming. Reset zeroes the accumulators
// and the element count, and sets metric to squared L2 and length to 1. Config
// writes are taken every cycle and restart the vector in progress.
module vector_distance_accumulator #(
	parameter int MAX_DIM = vda_pkg::MAX_DIM_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [vda_pkg::ELEM_W-1:0]     a_lane0,
	input  logic signed [vda_pkg::ELEM_W-1:0]     a_lane1,
	input  logic signed [vda_pkg::ELEM_W-1:0]     a_lane2,
	input  logic signed [vda_pkg::ELEM_W-1:0]     a_lane3,
	input  logic signed [vda_pkg::ELEM_W-1:0]     b_lane0,
	input  logic signed [vda_pkg::ELEM_W-1:0]     b_lane1,
	input  logic signed [vda_pkg::ELEM_W-1:0]     b_lane2,
	input  logic signed [vda_pkg::ELEM_W-1:0]     b_lane3,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [vda_pkg::ACC_W-1:0]      distance,
	output logic                                  zero_norm,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic        [vda_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic        [vda_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int CW = $clog2(MAX_DIM + vda_pkg::LANES + 1);
	localparam int XW = ((CW > vda_pkg::VLEN_W) ? CW : vda_pkg::VLEN_W) + 1;
	localparam logic [XW-1:0] MAX_LEN = XW'(MAX_DIM);

	logic [vda_pkg::METRIC_W-1:0] metric_q;
	logic [vda_pkg::VLEN_W-1:0]   vlen_q;
	logic [CW-1:0]                count_q;
	logic                         last_s1;
	vda_pkg::state_t              state_q, state_d;

	logic signed [vda_pkg::ELEM_W-1:0] a_arr [vda_pkg::LANES];
	logic signed [vda_pkg::ELEM_W-1:0] b_arr [vda_pkg::LANES];
	vda_pkg::lane_out_t                lane_q [vda_pkg::LANES];

	logic [XW-1:0] len, cnt_x;
	logic          take, is_last, cfg_wr, clear, load_out, cos_start, out_free;

	logic signed [vda_pkg::ACC_W-1:0] main_sum, norm_a, norm_b;
	logic        [vda_pkg::ACC_W-1:0] mag;
	logic signed [vda_pkg::ACC_W-1:0] fin_dist, cos_dist;
	logic                             fin_zn, need_cos;
	vda_pkg::cos_stat_t               cos_stat;
	logic        [vda_pkg::COS_Q_W-1:0] cos_q;

	logic signed [vda_pkg::ACC_W-1:0] dist_q;
	logic                             zn_q, out_valid_q;

	assign a_arr = '{a_lane0, a_lane1, a_lane2, a_lane3};
	assign b_arr = '{b_lane0, b_lane1, b_lane2, b_lane3};

	// effective length: zero acts as one, clamp to MAX_DIM
	always_comb begin
		len = XW'(vlen_q);
		if (len == '0) len = XW'(1);
		if (len > MAX_LEN) len = MAX_LEN;
	end

	assign cnt_x     = XW'(count_q);
	assign is_last   = (cnt_x + XW'(vda_pkg::LANES)) >= len;
	assign in_ready  = (state_q == vda_pkg::ST_ACC) && !last_s1;
	assign take      = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign out_free  = !out_valid_q || out_ready;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			metric_q <= vda_pkg::METRIC_L2;
			vlen_q   <= vda_pkg::VLEN_W'(1);
		end else if (cfg_wr) begin
			unique case (cfg_index)
				vda_pkg::REG_METRIC: metric_q <= cfg_data[vda_pkg::METRIC_W-1:0];
				vda_pkg::REG_VLEN:   vlen_q   <= cfg_data[vda_pkg::VLEN_W-1:0];
				default: ;
			endcase
		end
	end

	// element counter; wraps to zero on the last item of a vector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			last_s1 <= 1'b0;
		end else begin
			last_s1 <= take && is_last;
			if (cfg_wr) begin
				count_q <= '0;
			end else if (take) begin
				count_q <= is_last ? '0 : count_q + CW'(vda_pkg::LANES);
			end
		end
	end

	for (genvar i = 0; i < vda_pkg::LANES; i++) begin : g_lane
		vda_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.take     (take),
			.in_range ((cnt_x + XW'(i)) < len),
			.l2       (metric_q == vda_pkg::METRIC_L2),
			.a        (a_arr[i]),
			.b        (b_arr[i]),
			.q        (lane_q[i])
		);
	end

	assign clear = cfg_wr || load_out;

	vda_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (clear),
		.lanes    (lane_q),
		.main_sum (main_sum),
		.norm_a   (norm_a),
		.norm_b   (norm_b)
	);

	assign mag = main_sum[vda_pkg::ACC_W-1] ? vda_pkg::ACC_W'(-main_sum)
	                                        : vda_pkg::ACC_W'(main_sum);

	vda_cosine u_cos (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cos_start),
		.na     (norm_a),
		.nb     (norm_b),
		.mag    (mag),
		.stat   (cos_stat),
		.q      (cos_q)
	);

	// result for every case that needs no divide, cosine with a zero norm included; need_cos flags the rest
	always_comb begin
		fin_dist = '0;
		fin_zn   = 1'b0;
		need_cos = 1'b0;
		unique case (metric_q)
			vda_pkg::METRIC_L2:  fin_dist = main_sum;
			vda_pkg::METRIC_DOT: fin_dist = (main_sum == vda_pkg::ACC_MIN) ?
			                                vda_pkg::ACC_MAX : -main_sum;
			vda_pkg::METRIC_COS: begin
				if (norm_a == '0 || norm_b == '0) begin
					fin_zn = 1'b1;
				end else begin
					need_cos = 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign cos_dist = (main_sum > 0) ? -vda_pkg::ACC_W'(cos_q) : vda_pkg::ACC_W'(cos_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vda_pkg::ST_ACC;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		load_out  = 1'b0;
		cos_start = 1'b0;
		unique case (state_q)
			vda_pkg::ST_ACC: if (last_s1) state_d = vda_pkg::ST_FIN;
			vda_pkg::ST_FIN: begin
				if (need_cos) begin
					cos_start = 1'b1;
					state_d   = vda_pkg::ST_COS;
				end else if (out_free) begin
					load_out = 1'b1;
					state_d  = vda_pkg::ST_ACC;
				end
			end
			vda_pkg::ST_COS: begin
				if (cos_stat.done && out_free) begin
					load_out = 1'b1;
					state_d  = vda_pkg::ST_ACC;
				end
			end
			default: state_d = vda_pkg::ST_ACC;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			dist_q <= (state_q == vda_pkg::ST_COS) ? cos_dist : fin_dist;
			zn_q   <= (state_q == vda_pkg::ST_COS) ? 1'b0 : fin_zn;
		end
	end

	assign out_valid = out_valid_q;
	assign distance  = dist_q;
	assign zero_norm = zn_q;

endmodule

// ----- src/vda_checker.sv -----
// Port-level checks of the vector distance accumulator, bound to the top.
`include "assert_macros.svh"

module vda_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_ready,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic signed [vda_pkg::ACC_W-1:0]      distance,
	input logic                                  zero_norm,
	input logic                                  cfg_valid,
	input logic                                  cfg_ready
);

	`VDA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(distance))
	`VDA_ASSERT_SAME(a_zero_norm_dist, out_valid && zero_norm, distance == '0)
	`VDA_ASSERT_SAME(a_finish_blocks_in, $rose(out_valid), !$past(in_ready))
	`VDA_ASSERT_SAME(a_cfg_always_ready, cfg_valid, cfg_ready)

endmodule

bind vector_distance_accumulator vda_checker u_vda_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.distance  (distance),
	.zero_norm (zero_norm),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);
